// ----- design/s5auth_pkg.sv -----
// Shared definitions for the SOCKS5 username/password request parser:
// parser phase codes, credential defaults and byte helpers. No dependencies.
`default_nettype none

package s5auth_pkg;

    // largest credential the register file can hold, in bytes
    localparam int CRED_BYTES_MAX = 8;

    localparam logic [7:0] SUBNEG_VERSION = 8'h01;
    localparam logic [7:0] NUL_BYTE       = 8'h00;

    // credential defaults: "user" and "pass", first byte lowest
    localparam logic [63:0] USER_BYTES_RST  = 64'h0000_0000_7265_7375;
    localparam logic [63:0] PASS_BYTES_RST  = 64'h0000_0000_7373_6170;
    localparam logic [3:0]  USER_LENGTH_RST = 4'd4;
    localparam logic [3:0]  PASS_LENGTH_RST = 4'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_USER_BYTES  = 2'd0;
    localparam logic [1:0] REG_USER_LENGTH = 2'd1;
    localparam logic [1:0] REG_PASS_BYTES  = 2'd2;
    localparam logic [1:0] REG_PASS_LENGTH = 2'd3;

    // parser phases
    localparam logic [2:0] PH_VERSION = 3'd0;
    localparam logic [2:0] PH_ULEN    = 3'd1;
    localparam logic [2:0] PH_USER    = 3'd2;
    localparam logic [2:0] PH_PLEN    = 3'd3;
    localparam logic [2:0] PH_PASS    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    function automatic logic [7:0] f_cred_byte(input logic [63:0] creds,
                                               input logic [2:0]  idx);
        return creds[{idx, 3'b000} +: 8];
    endfunction

    // effective name length: length clamped to limit, cut at the first NUL
    function automatic logic [3:0] f_exp_len(input logic [63:0] creds,
                                             input logic [3:0]  len,
                                             input logic [3:0]  limit);
        logic [3:0] n;
        logic [3:0] res;
        n   = (len > limit) ? limit : len;
        res = n;
        for (int i = 7; i >= 0; i--) begin
            if ((4'(i) < n) && (f_cred_byte(creds, 3'(i)) == NUL_BYTE)) begin
                res = 4'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/socks5_user_pass_auth_parser.sv -----
// SOCKS5 username/password request parser, top level.
// Depends on s5auth_pkg (phase codes, credential defaults, helpers).
//
//   port group        | dir | handshake                  | payload
//   ------------------+-----+----------------------------+------------------------------
//   request bytes     | in  | i_in_valid / o_in_ready    | i_in_byte, i_new_exchange
//   auth reply        | out | o_out_valid / i_out_ready  | o_reply_version, o_status
//   credential regs   | in  | APB psel/penable/pready    | paddr, pwdata, prdata
//
// One byte a cycle unless the reply register stalls: a beat lands in the input
// register, is parsed from there and its reply (if any) is written to the output
// register. The input register only stalls when the reply register is full and
// not being taken. Synchronous active-low reset clears the parser, both pipeline
// registers and loads the default credentials.
`default_nettype none

module socks5_user_pass_auth_parser #(
    parameter int CRED_BYTES = s5auth_pkg::CRED_BYTES_MAX
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_new_exchange,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_reply_version,
    output logic             o_status,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import s5auth_pkg::*;

    localparam int         CRED_W     = 8 * CRED_BYTES;
    localparam logic [3:0] CRED_LIMIT = 4'(CRED_BYTES);

    // ---------------- credential registers ----------------
    logic [CRED_W-1:0] r_user_bytes;
    logic [3:0]        r_user_length;
    logic [CRED_W-1:0] r_pass_bytes;
    logic [3:0]        r_pass_length;
    logic [1:0]        w_reg_idx;
    logic              w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:3];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_bytes  <= USER_BYTES_RST[CRED_W-1:0];
            r_user_length <= USER_LENGTH_RST;
            r_pass_bytes  <= PASS_BYTES_RST[CRED_W-1:0];
            r_pass_length <= PASS_LENGTH_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_USER_BYTES:  r_user_bytes  <= pwdata[CRED_W-1:0];
                REG_USER_LENGTH: r_user_length <= pwdata[3:0];
                REG_PASS_BYTES:  r_pass_bytes  <= pwdata[CRED_W-1:0];
                REG_PASS_LENGTH: r_pass_length <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_USER_BYTES:  prdata = 64'(r_user_bytes);
            REG_USER_LENGTH: prdata = 64'(r_user_length);
            REG_PASS_BYTES:  prdata = 64'(r_pass_bytes);
            REG_PASS_LENGTH: prdata = 64'(r_pass_length);
            default:         prdata = '0;
        endcase
    end

    logic [63:0] w_user_creds;
    logic [63:0] w_pass_creds;
    logic [3:0]  w_user_exp;
    logic [3:0]  w_pass_exp;

    assign w_user_creds = 64'(r_user_bytes);
    assign w_pass_creds = 64'(r_pass_bytes);
    assign w_user_exp   = f_exp_len(w_user_creds, r_user_length, CRED_LIMIT);
    assign w_pass_exp   = f_exp_len(w_pass_creds, r_pass_length, CRED_LIMIT);

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;
    logic       w_proceed;

    assign w_proceed  = r_in_valid & (~o_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_new  <= i_new_exchange;
        end
    end

    // ---------------- parser state ----------------
    logic [2:0] r_phase;
    logic [7:0] r_field_len;
    logic [7:0] r_byte_pos;
    logic       r_name_match;
    logic       r_name_ended;
    logic       r_user_acc;

    logic [2:0] n_phase;
    logic [7:0] n_field_len;
    logic [7:0] n_byte_pos;
    logic       n_name_match;
    logic       n_name_ended;
    logic       n_user_acc;
    logic       w_res_valid;
    logic       w_res_status;

    always_comb begin
        logic [63:0] creds;
        logic [7:0]  exp8;
        logic [7:0]  b;
        logic        done_ok;

        n_phase      = r_phase;
        n_field_len  = r_field_len;
        n_byte_pos   = r_byte_pos;
        n_name_match = r_name_match;
        n_name_ended = r_name_ended;
        n_user_acc   = r_user_acc;
        w_res_valid  = 1'b0;
        w_res_status = STATUS_FAIL;
        b            = r_in_byte;

        if (r_in_new) begin
            n_phase      = PH_VERSION;
            n_field_len  = '0;
            n_byte_pos   = '0;
            n_name_match = 1'b1;
            n_name_ended = 1'b0;
            n_user_acc   = 1'b0;
        end

        creds   = (n_phase == PH_PASS) ? w_pass_creds : w_user_creds;
        exp8    = 8'((n_phase == PH_PASS) ? w_pass_exp : w_user_exp);
        done_ok = 1'b0;

        unique case (n_phase)
            PH_VERSION: begin
                if (b != SUBNEG_VERSION) begin
                    n_phase     = PH_DONE;
                    w_res_valid = 1'b1;
                end else begin
                    n_phase = PH_ULEN;
                end
            end
            PH_ULEN: begin
                if (b == NUL_BYTE) begin
                    n_phase     = PH_DONE;
                    w_res_valid = 1'b1;
                end else begin
                    n_field_len  = b;
                    n_byte_pos   = '0;
                    n_name_match = 1'b1;
                    n_name_ended = 1'b0;
                    n_phase      = PH_USER;
                end
            end
            PH_USER, PH_PASS: begin
                // compare one name byte; a NUL ends the name early
                if (!n_name_ended) begin
                    if (b == NUL_BYTE) begin
                        n_name_ended = 1'b1;
                        if (n_byte_pos != exp8) n_name_match = 1'b0;
                    end else if ((n_byte_pos >= exp8) ||
                                 (f_cred_byte(creds, n_byte_pos[2:0]) != b)) begin
                        n_name_match = 1'b0;
                    end
                end
                n_byte_pos = n_byte_pos + 8'd1;
                done_ok = n_name_ended ? n_name_match
                                       : (n_name_match && (n_field_len == exp8));
                if (n_byte_pos == n_field_len) begin
                    if (n_phase == PH_USER) begin
                        n_user_acc   = done_ok;
                        n_name_match = 1'b1;
                        n_name_ended = 1'b0;
                        n_byte_pos   = '0;
                        n_phase      = PH_PLEN;
                    end else begin
                        n_phase      = PH_DONE;
                        w_res_valid  = 1'b1;
                        w_res_status = (n_user_acc && done_ok) ? STATUS_OK : STATUS_FAIL;
                    end
                end
            end
            PH_PLEN: begin
                n_field_len  = b;
                n_byte_pos   = '0;
                n_name_match = 1'b1;
                n_name_ended = 1'b0;
                if (b == NUL_BYTE) begin
                    // empty password matches only an empty expected password
                    n_phase      = PH_DONE;
                    w_res_valid  = 1'b1;
                    w_res_status = (n_user_acc && (w_pass_exp == 4'd0)) ? STATUS_OK
                                                                          : STATUS_FAIL;
                end else begin
                    n_phase = PH_PASS;
                end
            end
            default: ;  // done: ignore bytes until a new exchange
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_VERSION;
            r_field_len  <= '0;
            r_byte_pos   <= '0;
            r_name_match <= 1'b1;
            r_name_ended <= 1'b0;
            r_user_acc   <= 1'b0;
        end else if (w_proceed) begin
            r_phase      <= n_phase;
            r_field_len  <= n_field_len;
            r_byte_pos   <= n_byte_pos;
            r_name_match <= n_name_match;
            r_name_ended <= n_name_ended;
            r_user_acc   <= n_user_acc;
        end
    end

    // ---------------- reply register ----------------
    logic r_out_valid;
    logic r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && w_res_valid) begin
            r_out_status <= w_res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_reply_version = SUBNEG_VERSION[0];

endmodule

`default_nettype wire
